[hw/rtl/rrd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_pkg: shared definitions of the read reply deframer
// Frame constants, status codes, register indexes and the result types.
// ----------------------------------------------------------------------------
package rrd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned POS_W      = 9;
	localparam int unsigned OFFSET_W   = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [BYTE_W-1:0] FRAME_START = 8'h57;
	localparam logic [BYTE_W-1:0] FRAME_ACK   = 8'h06;

	// Frame slots counted from the start byte.
	localparam logic [POS_W-1:0] SLOT_OFS_HI  = 9'd1;
	localparam logic [POS_W-1:0] SLOT_OFS_LO  = 9'd2;
	localparam logic [POS_W-1:0] SLOT_LENGTH  = 9'd3;
	localparam logic [POS_W-1:0] SLOT_DATA    = 9'd4;
	localparam logic [POS_W-1:0] SLOT_TRAILER = 9'd5;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_RESPONSE = 2'd1,
		ST_SUM_ERROR    = 2'd2
	} status_t;

	typedef struct packed {
		logic              is_data;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] data_index;
		logic              frame_done;
		status_t           status;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} step_t;

endpackage
`default_nettype wire

[hw/rtl/rrd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_in_if / rrd_out_if: item channels of the read reply deframer
// Valid and ready handshake with the received byte or the result fields.
// ----------------------------------------------------------------------------
interface rrd_in_if import rrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rrd_out_if import rrd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              is_data;
	logic [BYTE_W-1:0] data_byte;
	logic [BYTE_W-1:0] data_index;
	logic              frame_done;
	logic [1:0]        status;

	modport source (output valid, output is_data, output data_byte, output data_index,
		output frame_done, output status, input ready);
	modport sink (input valid, input is_data, input data_byte, input data_index,
		input frame_done, input status, output ready);
endinterface
`default_nettype wire

[hw/rtl/memory_read_reply_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// memory_read_reply_deframer_unit: block-read reply frame checker
// Checks a reply frame byte by byte and passes out its data bytes.
// ----------------------------------------------------------------------------
// Bytes of the reply enter on the rx channel, one item each. The frame is
// the start byte, the offset high and low bytes, the length, the data bytes,
// an additive checksum and the acknowledge byte. Each data byte leaves on
// the reply channel with its index, and the last byte of the frame leaves
// one item with frame_done set and a status of ok, bad response or checksum
// error. Header, checksum and trailer bytes that do not end the frame give
// no item. The expected offset and length are to be written on the cfg port
// only while the block is idle; the block itself does not enforce this, so the
// user is bound to it. An accepted byte is held in the input register, and
// its result is loaded into the output register when the frame checker takes
// it. One byte is accepted every cycle while the receiver takes the items;
// the only limit is the single pass through the frame checker between the two
// registers. When the receiver stalls, the output register holds its item;
// bytes that give no item still move on, and the next byte that gives one
// waits in the input register while rx ready is low. Reset empties both
// registers and starts a new frame.
// ----------------------------------------------------------------------------
module memory_read_reply_deframer_unit import rrd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	rrd_in_if.sink                     rx,
	rrd_out_if.source                  reply
);

	logic [OFFSET_W-1:0] expected_offset_q;
	logic [BYTE_W-1:0]   expected_length_q;
	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                out_free;
	logic                take;
	step_t               step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_offset_q <= '0;
			expected_length_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_EXPECTED_OFFSET: expected_offset_q <= cfg_wdata;
				REG_EXPECTED_LENGTH: expected_length_q <= cfg_wdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign take     = valid_s1 && (!step.valid || out_free);
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	rrd_frame_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.rx_byte         (byte_s1),
		.expected_offset (expected_offset_q),
		.expected_length (expected_length_q),
		.step            (step)
	);

	rrd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && step.valid),
		.load_res (step.res),
		.free     (out_free),
		.reply    (reply)
	);

`ifndef SYNTH
	a_data_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid |-> !(reply.is_data && reply.frame_done))
		else $error("result item is both a data byte and a frame end");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && reply.frame_done |-> reply.status != 2'd3)
		else $error("frame end carries an undefined status");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		take && step.valid |=> reply.valid)
		else $error("taken result item did not reach the output register");

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		reply.valid && reply.is_data |-> reply.status == ST_OK)
		else $error("data item carries a nonzero status");
`endif

endmodule
`default_nettype wire

[hw/rtl/rrd_frame_check.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_frame_check: frame position, checksum and fault tracking
// Works out the result of one byte and advances the frame state when taken.
// ----------------------------------------------------------------------------
module rrd_frame_check import rrd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [BYTE_W-1:0]   rx_byte,
	input  wire logic [OFFSET_W-1:0] expected_offset,
	input  wire logic [BYTE_W-1:0]   expected_length,
	output step_t                    step
);

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic              hdr_fault_q, hdr_fault_d;
	logic              sum_fault_q, sum_fault_d;
	logic [POS_W-1:0]  sum_slot, end_slot, data_pos;
	logic              hdr_final;

	assign sum_slot = {1'b0, expected_length} + SLOT_DATA;
	assign end_slot = {1'b0, expected_length} + SLOT_TRAILER;
	assign data_pos = pos_q - SLOT_DATA;

	always_comb begin
		pos_d       = pos_q;
		sum_d       = sum_q;
		hdr_fault_d = hdr_fault_q;
		sum_fault_d = sum_fault_q;
		hdr_final   = hdr_fault_q;
		step        = '0;
		step.res.status = ST_OK;
		if (pos_q >= end_slot) begin
			hdr_final = hdr_fault_q | (rx_byte != FRAME_ACK);
			step.valid          = 1'b1;
			step.res.frame_done = 1'b1;
			if (hdr_final) begin
				step.res.status = ST_BAD_RESPONSE;
			end else if (sum_fault_q) begin
				step.res.status = ST_SUM_ERROR;
			end
			pos_d       = '0;
			sum_d       = '0;
			hdr_fault_d = 1'b0;
			sum_fault_d = 1'b0;
		end else begin
			pos_d = pos_q + 9'd1;
			if (pos_q != '0 && pos_q < sum_slot) begin
				sum_d = sum_q + rx_byte;
			end
			if (pos_q == '0) begin
				hdr_fault_d = hdr_fault_q | (rx_byte != FRAME_START);
			end else if (pos_q == SLOT_OFS_HI) begin
				hdr_fault_d = hdr_fault_q | (rx_byte != expected_offset[15:8]);
			end else if (pos_q == SLOT_OFS_LO) begin
				hdr_fault_d = hdr_fault_q | (rx_byte != expected_offset[7:0]);
			end else if (pos_q == SLOT_LENGTH) begin
				hdr_fault_d = hdr_fault_q | (rx_byte != expected_length);
			end else if (pos_q < sum_slot) begin
				step.valid          = 1'b1;
				step.res.is_data    = 1'b1;
				step.res.data_byte  = rx_byte;
				step.res.data_index = data_pos[BYTE_W-1:0];
			end else begin
				sum_fault_d = sum_fault_q | (rx_byte != sum_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			hdr_fault_q <= 1'b0;
			sum_fault_q <= 1'b0;
		end else if (take) begin
			pos_q       <= pos_d;
			sum_q       <= sum_d;
			hdr_fault_q <= hdr_fault_d;
			sum_fault_q <= sum_fault_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/rrd_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrd_out_reg: result register of the read reply deframer
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module rrd_out_reg import rrd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire result_t  load_res,
	output logic          free,
	rrd_out_if.source     reply
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || reply.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= load_res;
		end
	end

	assign reply.valid      = valid_q;
	assign reply.is_data    = res_q.is_data;
	assign reply.data_byte  = res_q.data_byte;
	assign reply.data_index = res_q.data_index;
	assign reply.frame_done = res_q.frame_done;
	assign reply.status     = res_q.status;

endmodule
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: memory_read_reply_deframer_unit
// Feeds reply frames byte by byte with random idling on both channels and
// checks every reply item against a cycle-free model of the frame checker.
// ----------------------------------------------------------------------------
module testbench;
	import rrd_pkg::*;

	typedef logic [BYTE_W-1:0] byte_q_t[$];

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TARGET_BYTES   = 1050;

	class reply_checker;
		logic [OFFSET_W-1:0] exp_offset;
		logic [BYTE_W-1:0]   exp_length;
		logic [POS_W-1:0]    position;
		logic [BYTE_W-1:0]   running_sum;
		bit                  header_bad;
		bit                  sum_bad;
		result_t             expected_replies[$];
		int                  errors;
		int                  data_items;
		int                  ends_ok;
		int                  ends_bad;
		int                  ends_sum;

		function new();
			exp_offset  = '0;
			exp_length  = '0;
			position    = '0;
			running_sum = '0;
			header_bad  = 1'b0;
			sum_bad     = 1'b0;
			errors      = 0;
			data_items  = 0;
			ends_ok     = 0;
			ends_bad    = 0;
			ends_sum    = 0;
		endfunction

		function void load_config(logic [OFFSET_W-1:0] ofs, logic [BYTE_W-1:0] len);
			exp_offset = ofs;
			exp_length = len;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		// Bytes still needed to bring the frame count back to the start byte.
		function int bytes_to_frame_end();
			logic [POS_W-1:0] end_slot;
			end_slot = SLOT_TRAILER + exp_length;
			if (position == '0)
				return 0;
			if (position >= end_slot)
				return 1;
			return int'(end_slot - position) + 1;
		endfunction

		function void take_rx_byte(logic [BYTE_W-1:0] b);
			logic [POS_W-1:0] p;
			logic [POS_W-1:0] sum_slot;
			logic [POS_W-1:0] end_slot;
			result_t          r;
			p        = position;
			sum_slot = SLOT_DATA + exp_length;
			end_slot = SLOT_TRAILER + exp_length;
			r        = '0;
			if (p >= end_slot) begin
				if (b != FRAME_ACK)
					header_bad = 1'b1;
				r.frame_done = 1'b1;
				r.status     = header_bad ? ST_BAD_RESPONSE : (sum_bad ? ST_SUM_ERROR : ST_OK);
				expected_replies = {expected_replies, r};
				position    = '0;
				running_sum = '0;
				header_bad  = 1'b0;
				sum_bad     = 1'b0;
				return;
			end
			if (p >= SLOT_OFS_HI && p < sum_slot)
				running_sum = running_sum + b;
			position = p + 1'b1;
			if (p == '0) begin
				if (b != FRAME_START)
					header_bad = 1'b1;
			end else if (p == SLOT_OFS_HI) begin
				if (b != exp_offset[15:8])
					header_bad = 1'b1;
			end else if (p == SLOT_OFS_LO) begin
				if (b != exp_offset[7:0])
					header_bad = 1'b1;
			end else if (p == SLOT_LENGTH) begin
				if (b != exp_length)
					header_bad = 1'b1;
			end else if (p < sum_slot) begin
				r.is_data    = 1'b1;
				r.data_byte  = b;
				r.data_index = BYTE_W'(p - SLOT_DATA);
				expected_replies = {expected_replies, r};
			end else begin
				if (b != running_sum)
					sum_bad = 1'b1;
			end
		endfunction

		function void flag(string field, logic [BYTE_W-1:0] want_v, logic [BYTE_W-1:0] got_v);
			if (got_v !== want_v) begin
				$display("%0t: reply %s mismatch, expected %h actual %h",
					$time, field, want_v, got_v);
				errors++;
			end
		endfunction

		function void compare_reply(result_t got);
			result_t want;
			if (expected_replies.size() == 0) begin
				$display("%0t: reply item with nothing expected, expected none actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			flag("is_data", BYTE_W'(want.is_data), BYTE_W'(got.is_data));
			flag("data_byte", want.data_byte, got.data_byte);
			flag("data_index", want.data_index, got.data_index);
			flag("frame_done", BYTE_W'(want.frame_done), BYTE_W'(got.frame_done));
			flag("status", BYTE_W'(want.status), BYTE_W'(got.status));
			if (want.is_data)
				data_items++;
			if (want.frame_done) begin
				case (want.status)
					ST_OK:           ends_ok++;
					ST_BAD_RESPONSE: ends_bad++;
					default:         ends_sum++;
				endcase
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	rrd_in_if  rx_ch ();
	rrd_out_if reply_ch ();

	reply_checker tracker;
	int           send_idle_pct  = 10;
	int           recv_stall_pct = 48;
	int           bytes_sent     = 0;
	int           settings_used  = 0;
	int           idle_cycles    = 0;

	memory_read_reply_deframer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.reply     (reply_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		tracker.take_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_bytes(input byte_q_t q);
		foreach (q[i])
			send_byte(q[i]);
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [OFFSET_W-1:0] ofs, input logic [BYTE_W-1:0] len);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_EXPECTED_OFFSET;
		cfg_wdata <= ofs;
		@(posedge clk);
		cfg_index <= REG_EXPECTED_LENGTH;
		cfg_wdata <= {BYTE_W'($urandom), len};
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.load_config(ofs, len);
		settings_used++;
	endtask

	function automatic byte_q_t build_frame(logic [OFFSET_W-1:0] ofs, logic [BYTE_W-1:0] len);
		byte_q_t           q;
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] d;
		q   = {FRAME_START, ofs[15:8], ofs[7:0], len};
		sum = ofs[15:8] + ofs[7:0] + len;
		for (int i = 0; i < int'(len); i++) begin
			d = BYTE_W'($urandom);
			q = {q, d};
			sum = sum + d;
		end
		q = {q, sum, FRAME_ACK};
		return q;
	endfunction

	initial begin
		result_t got;
		forever begin
			@(posedge clk);
			if (reply_ch.valid && reply_ch.ready) begin
				got.is_data    = reply_ch.is_data;
				got.data_byte  = reply_ch.data_byte;
				got.data_index = reply_ch.data_index;
				got.frame_done = reply_ch.frame_done;
				got.status     = status_t'(reply_ch.status);
				tracker.compare_reply(got);
			end
			reply_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((rx_ch.valid && rx_ch.ready) || (reply_ch.valid && reply_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	initial begin
		byte_q_t             q;
		logic [OFFSET_W-1:0] ofs;
		logic [BYTE_W-1:0]   len;
		int                  n_frames;
		int                  long_frames;
		tracker        = new();
		long_frames    = 0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		reply_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Good frame at the top offset, data bytes at both extremes.
		write_config(16'hffff, 8'd2);
		send_bytes('{FRAME_START, 8'hff, 8'hff, 8'h02, 8'h00, 8'hff, 8'hff, FRAME_ACK});
		settle();

		// A bad start byte together with a bad checksum must report a bad response.
		write_config(16'h0000, 8'd0);
		q    = build_frame(16'h0000, 8'd0);
		q[0] = 8'h58;
		q[4] = q[4] ^ 8'h01;
		send_bytes(q);
		settle();

		// Length shrinks mid-frame, so the next byte is taken as the trailer.
		write_config(16'h0000, 8'd3);
		send_bytes('{FRAME_START, 8'h00, 8'h00, 8'h03, 8'h5a, 8'ha5});
		settle();
		write_config(16'h0000, 8'd0);
		send_byte(FRAME_ACK);
		settle();

		// Offset changes between its high and low byte.
		write_config(16'h1200, 8'd0);
		send_bytes('{FRAME_START, 8'h12});
		settle();
		write_config(16'h1234, 8'd0);
		send_bytes('{8'h34, 8'h00, 8'h46, FRAME_ACK});

		while (bytes_sent < TARGET_BYTES) begin
			if (bytes_sent < TARGET_BYTES / 3) begin
				send_idle_pct  = 10;
				recv_stall_pct = 48;
			end else if (bytes_sent < 2 * TARGET_BYTES / 3) begin
				send_idle_pct  = 48;
				recv_stall_pct = 10;
			end else begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			settle();
			case ($urandom_range(7))
				0:       ofs = 16'h0000;
				1:       ofs = 16'hffff;
				default: ofs = OFFSET_W'($urandom);
			endcase
			n_frames = $urandom_range(1, 4);
			if (long_frames < 2 && bytes_sent > 200 && $urandom_range(24) == 0) begin
				len = 8'd255;
				n_frames = 1;
				long_frames++;
			end else if ($urandom_range(3) == 0) begin
				len = BYTE_W'($urandom_range(40));
			end else begin
				len = BYTE_W'($urandom_range(8));
			end
			write_config(ofs, len);
			repeat (n_frames) begin
				if (tracker.bytes_to_frame_end() != 0 && $urandom_range(99) < 85)
					repeat (tracker.bytes_to_frame_end())
						send_byte(BYTE_W'($urandom));
				q = build_frame(ofs, len);
				case ($urandom_range(9))
					0, 1: begin
						n_frames = $urandom_range(q.size() - 1);
						q[n_frames] = q[n_frames] ^ BYTE_W'($urandom_range(1, 255));
					end
					2: repeat ($urandom_range(1, 3))
						send_byte(BYTE_W'($urandom));
					3: q = q[0:$urandom_range(q.size() - 2)];
					default: ;
				endcase
				send_bytes(q);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Run covered %0d received bytes under %0d register settings,",
			bytes_sent, settings_used);
		$display("with %0d data items and %0d ok, %0d bad response, %0d checksum frame ends.",
			tracker.data_items, tracker.ends_ok, tracker.ends_bad, tracker.ends_sum);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
